>>> rtl/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared constants, codes and types of the CSV field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

   // characters of interest
   localparam logic [7:0] CHAR_COMMA    = 8'h2C;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_VTAB     = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED = 8'h0C;
   localparam logic [7:0] CHAR_CR       = 8'h0D;

   // field widths of the channels
   localparam int DATA_BITS       = 8;
   localparam int ROW_BITS        = 32;
   localparam int COL_OUT_BITS    = 6;
   localparam int OUT_OFFSET_BITS = 32;
   localparam int WIDE_BITS       = 64;

   // configuration port
   localparam int CSR_INDEX_BITS  = 8;
   localparam int CSR_DATA_BITS   = 64;
   localparam int HEADER_ROW_BITS = 32;
   localparam int KEEP_MASK_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEADER_ROW = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEEP_MASK  = 8'd1;

   // queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   // finished field, as handed from the front to the back
   typedef struct packed {
      logic [ROW_BITS-1:0]     row;
      logic [COL_OUT_BITS-1:0] column;
      logic                    has_text;
      logic                    first_quote;
      logic                    last_quote;
      logic                    header;
   } field_ctl_type;

   function automatic logic is_space_char(input logic [7:0] c);
      return c inside {CHAR_SPACE, CHAR_FORMFEED, CHAR_NEWLINE, CHAR_CR, CHAR_TAB, CHAR_VTAB};
   endfunction

endpackage

`default_nettype wire

>>> rtl/csvt_if.sv
// ----------------------------------------------------------------------------
// csvt channel interfaces
// Valid/ready channels for input bytes and for finished field words.
// ----------------------------------------------------------------------------
`default_nettype none

interface csvt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface csvt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] row_index;
   logic [5:0]  column_index;
   logic [31:0] text_start;
   logic [31:0] text_end;
   logic        field_empty;
   logic        is_header;

   modport source (output valid, output row_index, output column_index,
                   output text_start, output text_end, output field_empty,
                   output is_header, input ready);
   modport sink   (input valid, input row_index, input column_index,
                   input text_start, input text_end, input field_empty,
                   input is_header, output ready);
endinterface

`default_nettype wire

>>> rtl/csvt_front.sv
// ----------------------------------------------------------------------------
// csvt_front
// Takes one byte a cycle while push_ready is high; tracks quotes, counters
// and the field's text bounds; pushes a record per kept field a delimiter ends.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_front
   import csvt_pkg::*;
#(
   parameter int MAX_COLUMNS = 64,
   parameter int OFFSET_BITS = 32
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_write_en,
   input  wire [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [CSR_DATA_BITS-1:0]    csr_write_data,
   csvt_req_if.sink                   req_bus,
   output logic                       push_valid,
   input  wire                        push_ready,
   output field_ctl_type              push_ctl,
   output logic [OFFSET_BITS-1:0]     push_first,
   output logic [OFFSET_BITS-1:0]     push_last
);

   localparam int COL_BITS = $clog2(MAX_COLUMNS + 1);

   logic [HEADER_ROW_BITS-1:0] header_row_ff;
   logic [KEEP_MASK_BITS-1:0]  keep_mask_ff;

   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic                   inq_ff, inq_in;
   logic                   has_text_ff, has_text_in;
   logic [OFFSET_BITS-1:0] first_ff, first_in;
   logic [OFFSET_BITS-1:0] last_ff, last_in;
   logic                   fq_ff, fq_in;
   logic                   lq_ff, lq_in;

   logic                   accept;
   logic                   is_quote;
   logic                   ends_field;
   logic                   take_en;
   logic                   col_open;
   logic [COL_OUT_BITS-1:0] col_idx;

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid && push_ready;

   assign is_quote   = (req_bus.data_byte == CHAR_QUOTE);
   assign ends_field = !inq_ff && ((req_bus.data_byte == CHAR_COMMA) ||
                                   (req_bus.data_byte == CHAR_NEWLINE));
   assign take_en    = accept && !ends_field && !is_space_char(req_bus.data_byte);
   assign col_open   = (col_ff < COL_BITS'(MAX_COLUMNS));
   assign col_idx    = COL_OUT_BITS'(col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_row_ff <= '0;
         keep_mask_ff  <= '1;
      end else if (csr_write_en) begin
         if (csr_index == CSR_HEADER_ROW) begin
            header_row_ff <= csr_write_data[HEADER_ROW_BITS-1:0];
         end else if (csr_index == CSR_KEEP_MASK) begin
            keep_mask_ff <= csr_write_data[KEEP_MASK_BITS-1:0];
         end
      end
   end

   always_comb begin
      offset_in   = offset_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      inq_in      = inq_ff;
      has_text_in = has_text_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      fq_in       = fq_ff;
      lq_in       = lq_ff;
      push_valid  = 1'b0;

      if (accept) begin
         offset_in = offset_ff + 1'b1;
         if (is_quote) begin
            inq_in = !inq_ff;
         end
         if (ends_field) begin
            if (row_ff >= header_row_ff) begin
               if (col_open && keep_mask_ff[col_idx]) begin
                  push_valid = 1'b1;
               end
               if (col_open) begin
                  col_in = col_ff + 1'b1;
               end
            end
            has_text_in = 1'b0;
            first_in    = '0;
            last_in     = '0;
            fq_in       = 1'b0;
            lq_in       = 1'b0;
            inq_in      = 1'b0;
            if (req_bus.data_byte == CHAR_NEWLINE) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end
         end
      end

      // non-whitespace byte widens the field's text bounds
      if (take_en) begin
         if (!has_text_ff) begin
            has_text_in = 1'b1;
            first_in    = offset_ff;
            fq_in       = is_quote;
         end
         last_in = offset_ff;
         lq_in   = is_quote;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         inq_ff      <= 1'b0;
         has_text_ff <= 1'b0;
         first_ff    <= '0;
         last_ff     <= '0;
         fq_ff       <= 1'b0;
         lq_ff       <= 1'b0;
      end else begin
         offset_ff   <= offset_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         inq_ff      <= inq_in;
         has_text_ff <= has_text_in;
         first_ff    <= first_in;
         last_ff     <= last_in;
         fq_ff       <= fq_in;
         lq_ff       <= lq_in;
      end
   end

   always_comb begin
      push_ctl.row         = row_ff;
      push_ctl.column      = col_idx;
      push_ctl.has_text    = has_text_ff;
      push_ctl.first_quote = fq_ff;
      push_ctl.last_quote  = lq_ff;
      push_ctl.header      = (row_ff == header_row_ff);
   end

   assign push_first = first_ff;
   assign push_last  = last_ff;

endmodule

`default_nettype wire

>>> rtl/csvt_queue.sv
// ----------------------------------------------------------------------------
// csvt_queue
// Two-entry queue between the front and the back of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_queue
   import csvt_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push_valid,
   output logic             push_ready,
   input  wire [WIDTH-1:0]  push_data,
   output logic             pop_valid,
   input  wire              pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/csvt_back.sv
// ----------------------------------------------------------------------------
// csvt_back
// Strips one surrounding quote pair, forms the reported span and holds the
// result word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_back
   import csvt_pkg::*;
#(
   parameter int OFFSET_BITS = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     pop_valid,
   output logic                    pop_ready,
   input  field_ctl_type           pop_ctl,
   input  wire [OFFSET_BITS-1:0]   pop_first,
   input  wire [OFFSET_BITS-1:0]   pop_last,
   csvt_rsp_if.source              rsp_bus
);

   logic                       valid_ff, valid_in;
   logic [ROW_BITS-1:0]        row_ff;
   logic [COL_OUT_BITS-1:0]    col_ff;
   logic [OUT_OFFSET_BITS-1:0] start_ff, start_in;
   logic [OUT_OFFSET_BITS-1:0] end_ff, end_in;
   logic                       empty_ff, empty_in;
   logic                       header_ff;

   logic                       load;
   logic [OFFSET_BITS-1:0]     span_len;
   logic [OFFSET_BITS-1:0]     start_off;
   logic [OFFSET_BITS-1:0]     end_off;
   logic [WIDE_BITS-1:0]       start_wide;
   logic [WIDE_BITS-1:0]       end_wide;

   assign pop_ready = !valid_ff || rsp_bus.ready;
   assign load      = pop_valid && pop_ready;
   assign span_len  = pop_last - pop_first;

   always_comb begin
      start_off = '0;
      end_off   = '0;
      empty_in  = 1'b1;
      if (pop_ctl.has_text) begin
         if (pop_ctl.first_quote && pop_ctl.last_quote) begin
            // a lone quote or two adjacent quotes leave nothing
            if (span_len >= OFFSET_BITS'(2)) begin
               start_off = pop_first + 1'b1;
               end_off   = pop_last - 1'b1;
               empty_in  = 1'b0;
            end
         end else begin
            start_off = pop_first;
            end_off   = pop_last;
            empty_in  = 1'b0;
         end
      end
      start_wide = WIDE_BITS'(start_off);
      end_wide   = WIDE_BITS'(end_off);
      start_in   = start_wide[OUT_OFFSET_BITS-1:0];
      end_in     = end_wide[OUT_OFFSET_BITS-1:0];
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff    <= pop_ctl.row;
         col_ff    <= pop_ctl.column;
         start_ff  <= start_in;
         end_ff    <= end_in;
         empty_ff  <= empty_in;
         header_ff <= pop_ctl.header;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.row_index    = row_ff;
   assign rsp_bus.column_index = col_ff;
   assign rsp_bus.text_start   = start_ff;
   assign rsp_bus.text_end     = end_ff;
   assign rsp_bus.field_empty  = empty_ff;
   assign rsp_bus.is_header    = header_ff;

endmodule

`default_nettype wire

>>> rtl/csv_field_tokenizer_top.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_top
// Splits a CSV byte stream into fields and reports each kept field's span.
//
// req_bus carries one text byte per word; rsp_bus carries one word per kept
// field: row, column, trimmed and unquoted span, empty and header flags.
// csr_* writes header_row_index (index 0) and column_keep_mask (index 1);
// other indexes are ignored. Write registers only while the block is idle.
// Throughput is one byte per cycle while the queue has space, set by the
// front's update of the offset, row, column and quote state for each byte.
// The word for a field is written into the two-entry queue by the edge that
// accepts its comma or newline, and from there is loaded into the output
// register that drives rsp_bus.
// A stalled rsp_bus fills the output register and then the queue; req_bus
// ready drops only once the queue is full, and then no byte is taken, even
// one that ends no kept field, so ready depends on queue space alone.
// Reset clears all counters, the quote state, the queue and the output
// valid, sets header_row_index to 0 and column_keep_mask to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer_top
   import csvt_pkg::*;
#(
   parameter int MAX_COLUMNS = 64,
   parameter int OFFSET_BITS = 32
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      csr_write_en,
   input  wire [CSR_INDEX_BITS-1:0] csr_index,
   input  wire [CSR_DATA_BITS-1:0]  csr_write_data,
   csvt_req_if.sink                 req_bus,
   csvt_rsp_if.source               rsp_bus
);

   localparam int CTL_BITS = $bits(field_ctl_type);
   localparam int Q_BITS   = CTL_BITS + 2 * OFFSET_BITS;

   logic                   push_valid;
   logic                   push_ready;
   field_ctl_type          push_ctl;
   logic [OFFSET_BITS-1:0] push_first;
   logic [OFFSET_BITS-1:0] push_last;
   logic [Q_BITS-1:0]      push_data;

   logic                   pop_valid;
   logic                   pop_ready;
   logic [Q_BITS-1:0]      pop_data;
   field_ctl_type          pop_ctl;
   logic [OFFSET_BITS-1:0] pop_first;
   logic [OFFSET_BITS-1:0] pop_last;

   csvt_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_bus        (req_bus),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_ctl       (push_ctl),
      .push_first     (push_first),
      .push_last      (push_last)
   );

   assign push_data = {push_ctl, push_first, push_last};

   csvt_queue #(
      .WIDTH (Q_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_ctl   = pop_data[Q_BITS-1 -: CTL_BITS];
   assign pop_first = pop_data[2*OFFSET_BITS-1 -: OFFSET_BITS];
   assign pop_last  = pop_data[OFFSET_BITS-1:0];

   csvt_back #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_ctl   (pop_ctl),
      .pop_first (pop_first),
      .pop_last  (pop_last),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams directed and random CSV text into csv_field_tokenizer_top with
// random gaps on the byte side and random stalls on the field side. A local
// tokenizer model predicts each field word, and the monitor compares the
// fields of every word with the oldest prediction. Header row and column mask
// are changed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;
   import csvt_pkg::*;

   localparam int MAX_COLS      = 64;
   localparam int SETTLE_CYCLES = 6;
   localparam int QUIET_LIMIT   = 2000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 8'hFF;

   typedef struct {
      logic [ROW_BITS-1:0]        row;
      logic [COL_OUT_BITS-1:0]    column;
      logic [OUT_OFFSET_BITS-1:0] start_ofs;
      logic [OUT_OFFSET_BITS-1:0] end_ofs;
      logic                       empty;
      logic                       header;
   } field_span_type;

   logic clock;
   logic reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   csvt_req_if req_bus ();
   csvt_rsp_if rsp_bus ();

   csv_field_tokenizer_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus)
   );

   // tokenizer model state and registers
   logic [HEADER_ROW_BITS-1:0] hdr_line   = '0;
   logic [KEEP_MASK_BITS-1:0]  keep_mask  = '1;
   logic [31:0] scan_offset = '0;
   logic [31:0] line_count  = '0;
   logic [6:0]  col_count   = '0;
   logic        in_quotes   = 1'b0;
   logic        span_open   = 1'b0;
   logic [31:0] span_first  = '0;
   logic [31:0] span_last   = '0;
   logic        first_quote = 1'b0;
   logic        last_quote  = 1'b0;

   logic [7:0]     text_bytes[$];
   field_span_type field_spans[$];
   int          phase_bytes = 0;
   int          error_count = 0;
   int          quiet_cycles = 0;

   bit req_taken = 1'b0;
   bit req_idle  = 1'b1;
   int req_gap   = 0;
   bit rsp_idle  = 1'b1;
   int rsp_hold  = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns  mismatch: %s", $time, what);
      error_count++;
   endtask

   task automatic note_text(input logic [7:0] c, input logic [31:0] pos);
      if (!(c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NEWLINE || c == CHAR_VTAB ||
            c == CHAR_FORMFEED || c == CHAR_CR)) begin
         if (!span_open) begin
            span_open   = 1'b1;
            span_first  = pos;
            first_quote = (c == CHAR_QUOTE);
         end
         span_last  = pos;
         last_quote = (c == CHAR_QUOTE);
      end
   endtask

   // advance the tokenizer by one byte, queueing the field word it finishes
   task automatic tokenize_byte(input logic [7:0] c);
      logic [31:0] pos;
      field_span_type span;
      pos = scan_offset;
      if (c == CHAR_QUOTE) begin
         in_quotes = !in_quotes;
         note_text(c, pos);
      end else if ((c == CHAR_COMMA || c == CHAR_NEWLINE) && !in_quotes) begin
         if (line_count >= hdr_line) begin
            if (col_count < MAX_COLS && keep_mask[col_count[5:0]]) begin
               span.row       = line_count;
               span.column    = col_count[5:0];
               span.start_ofs = '0;
               span.end_ofs   = '0;
               span.empty     = 1'b1;
               span.header    = (line_count == hdr_line);
               if (span_open) begin
                  // one surrounding quote pair is stripped
                  if (first_quote && last_quote) begin
                     if (span_last - span_first >= 2) begin
                        span.start_ofs = span_first + 1;
                        span.end_ofs   = span_last - 1;
                        span.empty     = 1'b0;
                     end
                  end else begin
                     span.start_ofs = span_first;
                     span.end_ofs   = span_last;
                     span.empty     = 1'b0;
                  end
               end
               field_spans.insert(field_spans.size(), span);
            end
            if (col_count < MAX_COLS) col_count++;
         end
         span_open   = 1'b0;
         span_first  = '0;
         span_last   = '0;
         first_quote = 1'b0;
         last_quote  = 1'b0;
         in_quotes   = 1'b0;
         if (c == CHAR_NEWLINE) begin
            col_count  = '0;
            line_count = line_count + 1;
         end
      end else begin
         note_text(c, pos);
      end
      scan_offset = pos + 1;
   endtask

   // byte driver
   always @(negedge clock) begin
      if (!req_bus.valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap != 0) begin
            req_bus.valid <= 1'b0;
            req_gap--;
         end else if (text_bytes.size() != 0) begin
            req_bus.valid     <= 1'b1;
            req_bus.data_byte <= text_bytes.pop_front();
            if ($urandom_range(0, 63) == 0) req_idle = !req_idle;
            req_gap = req_idle ? $urandom_range(0, 9) : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // field word receiver stalls
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      field_span_type want;
      if (!reset) begin
         quiet_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            tokenize_byte(req_bus.data_byte);
            req_taken    = 1'b1;
            quiet_cycles = 0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            quiet_cycles = 0;
            if ($urandom_range(0, 63) == 0) rsp_idle = !rsp_idle;
            rsp_hold = rsp_idle ? $urandom_range(0, 9) : 0;
            if (field_spans.size() == 0) begin
               report_mismatch($sformatf("unexpected word row %0d column %0d",
                                         rsp_bus.row_index, rsp_bus.column_index));
            end else begin
               want = field_spans.pop_front();
               if (rsp_bus.row_index !== want.row)
                  report_mismatch($sformatf("row_index got %0d want %0d",
                                            rsp_bus.row_index, want.row));
               if (rsp_bus.column_index !== want.column)
                  report_mismatch($sformatf("column_index got %0d want %0d",
                                            rsp_bus.column_index, want.column));
               if (rsp_bus.text_start !== want.start_ofs)
                  report_mismatch($sformatf("text_start got %0d want %0d",
                                            rsp_bus.text_start, want.start_ofs));
               if (rsp_bus.text_end !== want.end_ofs)
                  report_mismatch($sformatf("text_end got %0d want %0d",
                                            rsp_bus.text_end, want.end_ofs));
               if (rsp_bus.field_empty !== want.empty)
                  report_mismatch($sformatf("field_empty got %b want %b",
                                            rsp_bus.field_empty, want.empty));
               if (rsp_bus.is_header !== want.header)
                  report_mismatch($sformatf("is_header got %b want %b",
                                            rsp_bus.is_header, want.header));
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("csv_field_tokenizer_top test failed");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] c);
      text_bytes.insert(text_bytes.size(), c);
      phase_bytes++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 4))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_CR;
         3: return CHAR_VTAB;
         default: return CHAR_FORMFEED;
      endcase
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom);
      while (c == CHAR_QUOTE || c == CHAR_COMMA || c == CHAR_NEWLINE);
      return c;
   endfunction

   task automatic push_field(input int max_len);
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, max_len);
      if ($urandom_range(0, 3) == 0) push_byte(pick_space());
      case (kind)
         0: ;
         1, 2, 3, 4, 5: repeat (len) push_byte(plain_byte());
         6, 7, 8: begin
            push_byte(CHAR_QUOTE);
            repeat (len) begin
               case ($urandom_range(0, 7))
                  0: push_byte(CHAR_COMMA);
                  1: push_byte(CHAR_NEWLINE);
                  2: begin
                     push_byte(CHAR_QUOTE);
                     push_byte(CHAR_QUOTE);
                  end
                  default: push_byte(plain_byte());
               endcase
            end
            push_byte(CHAR_QUOTE);
         end
         default: repeat (len) push_byte(8'($urandom));
      endcase
      if ($urandom_range(0, 3) == 0) push_byte(pick_space());
   endtask

   task automatic push_row(input int fields, input int max_len);
      for (int i = 0; i < fields; i++) begin
         push_field(max_len);
         push_byte((i == fields - 1) ? CHAR_NEWLINE : CHAR_COMMA);
      end
   endtask

   // mostly well-formed rows, some bursts of separators, quotes and raw bytes
   task automatic feed_rows(input int target);
      phase_bytes = 0;
      while (phase_bytes < target) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 3))
                  0: push_byte(CHAR_QUOTE);
                  1: push_byte(CHAR_COMMA);
                  2: push_byte(CHAR_NEWLINE);
                  default: push_byte(8'($urandom));
               endcase
            end
         end else begin
            push_row($urandom_range(1, 6), 4);
         end
      end
   endtask

   task automatic settle();
      while (text_bytes.size() != 0 || req_bus.valid || field_spans.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      if (idx == CSR_HEADER_ROW) hdr_line = value[HEADER_ROW_BITS-1:0];
      else if (idx == CSR_KEEP_MASK) keep_mask = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = '0;
      rsp_bus.ready      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: single byte, whitespace only, quoted, adjacent quotes,
      // quote spanning separators, extreme byte values
      push_text("a,");
      push_byte(CHAR_SPACE);
      push_byte(CHAR_TAB);
      push_byte(CHAR_CR);
      push_byte(CHAR_VTAB);
      push_byte(CHAR_FORMFEED);
      push_byte(CHAR_COMMA);
      push_text("\"x\",");
      push_text("\"\",");
      push_text("\"p,");
      push_byte(CHAR_NEWLINE);
      push_text("q\",");
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(CHAR_NEWLINE);
      settle();

      // header two rows ahead, random column mask
      write_reg(CSR_HEADER_ROW, 64'(line_count + 2));
      write_reg(CSR_KEEP_MASK, {$urandom, $urandom});
      feed_rows(120);
      settle();

      // every column masked off
      write_reg(CSR_HEADER_ROW, '0);
      write_reg(CSR_KEEP_MASK, '0);
      feed_rows(40);
      settle();

      // header row out of reach
      write_reg(CSR_HEADER_ROW, 64'hFFFF_FFFF);
      write_reg(CSR_KEEP_MASK, '1);
      feed_rows(30);
      settle();

      // unknown register, then rows wider than the column limit
      write_reg(CSR_SPARE_INDEX, 64'h0);
      write_reg(CSR_HEADER_ROW, 64'(line_count));
      phase_bytes = 0;
      push_row(70, 1);
      push_row(MAX_COLS + 2, 2);
      settle();

      write_reg(CSR_HEADER_ROW, '0);
      write_reg(CSR_KEEP_MASK, {$urandom, $urandom} | 64'hFFFF);
      feed_rows(150);
      settle();

      if (field_spans.size() != 0)
         report_mismatch($sformatf("%0d field words never arrived", field_spans.size()));
      if (error_count == 0) begin
         $display("csv_field_tokenizer_top test passed");
      end else begin
         $display("csv_field_tokenizer_top test failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/csvt_pkg.sv
rtl/csvt_if.sv
rtl/csvt_front.sv
rtl/csvt_queue.sv
rtl/csvt_back.sv
rtl/csv_field_tokenizer_top.sv
verif/tb_top.sv
